// ----- rtl/mnes_pkg.sv -----
// shared types and constants for the masked neighbour estimate stencil
package mnes_pkg;

    localparam int DEFAULT_MAX_ROWS = 1024;
    localparam int DIV_BITS         = 19;
    localparam int CNT_W            = $clog2(DIV_BITS);
    localparam int CFG_DATA_W       = 16;

    localparam logic [1:0] REG_ESTIMATE_MODE = 2'd0;
    localparam logic [1:0] REG_ROWS_IN_USE   = 2'd1;
    localparam logic [1:0] REG_COLS_IN_USE   = 2'd2;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               is_missing;
    } in_beat_t;

    typedef struct packed {
        logic signed [19:0] estimate;
        logic               no_divisor;
        logic [9:0]         centre_row;
        logic [15:0]        centre_col;
        logic               last_of_image;
    } out_beat_t;

    typedef struct packed {
        logic capture;
        logic rd_here;
        logic rd_other;
        logic win_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } mnes_cmd_t;

    typedef struct packed {
        logic interior;
        logic out_free;
    } mnes_status_t;

endpackage

// ----- rtl/masked_neighbour_estimate_stencil_unit.sv -----
// top level of the masked 3x3 neighbour estimate stencil
// A border input beat passes through the two column store reads and the window
// update before the next beat is accepted; an interior pixel with an estimate
// goes on through the weighted sum, the bit-serial divider and the output load,
// and may wait for a free output register. The output register holds one finished
// beat while the next pixel is taken in. The column store is not cleared after reset.
module masked_neighbour_estimate_stencil_unit
#(
    parameter int MAX_ROWS = mnes_pkg::DEFAULT_MAX_ROWS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mnes_pkg::in_beat_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mnes_pkg::out_beat_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [mnes_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mnes_pkg::*;

    mnes_cmd_t    cmd;
    mnes_status_t status;

    assign cfg_ready = 1'b1;

    mnes_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mnes_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- rtl/mnes_ctrl.sv -----
// controller state machine sequencing one pixel through the datapath
module mnes_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  mnes_pkg::mnes_status_t status,
    output mnes_pkg::mnes_cmd_t    cmd
);
    import mnes_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_HERE,
        ST_RD_OTHER,
        ST_WIN,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RD_HERE;
                end
            end
            ST_RD_HERE:  state_next = ST_RD_OTHER;
            ST_RD_OTHER: state_next = ST_WIN;
            ST_WIN:      state_next = status.interior ? ST_SUM : ST_IDLE;
            ST_SUM:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_BITS - 1))
                begin
                    state_next = ST_OUT;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.capture   = (state_reg == ST_IDLE) && in_valid;
        cmd.rd_here   = (state_reg == ST_RD_HERE);
        cmd.rd_other  = (state_reg == ST_RD_OTHER);
        cmd.win_step  = (state_reg == ST_WIN);
        cmd.div_start = (state_reg == ST_SUM);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.out_load  = (state_reg == ST_OUT) && status.out_free;
    end

endmodule

// ----- rtl/mnes_dp.sv -----
// datapath: registers, column store, window, weighted sum, divider, output beat
module mnes_dp
#(
    parameter int MAX_ROWS = mnes_pkg::DEFAULT_MAX_ROWS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  mnes_pkg::in_beat_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output mnes_pkg::out_beat_t                out_data,
    input  logic                               cfg_valid,
    input  logic [1:0]                         cfg_index,
    input  logic [mnes_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  mnes_pkg::mnes_cmd_t                cmd,
    output mnes_pkg::mnes_status_t             status
);
    import mnes_pkg::*;

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int NRW0 = $clog2(MAX_ROWS + 1);
    localparam int NRW  = (NRW0 > 11) ? NRW0 : 11;
    localparam int AW   = RW + 1;

    // configuration
    logic        mode_reg;
    logic [10:0] rows_reg;
    logic [15:0] cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            rows_reg <= 11'd1024;
            cols_reg <= 16'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ESTIMATE_MODE: mode_reg <= cfg_data[0];
                REG_ROWS_IN_USE:   rows_reg <= cfg_data[10:0];
                REG_COLS_IN_USE:   cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // geometry
    logic [NRW-1:0] nr;
    logic [15:0]    nc;
    logic [RW-1:0]  rpos_reg, rpos_next;
    logic [15:0]    cpos_reg, cpos_next;
    logic [RW-1:0]  r_cur;
    logic [15:0]    c_cur;
    logic [NRW-1:0] r_ext;
    logic [16:0]    c_inc;

    always_comb
    begin
        if (NRW'(rows_reg) < NRW'(3))
        begin
            nr = NRW'(3);
        end
        else if (NRW'(rows_reg) > NRW'(MAX_ROWS))
        begin
            nr = NRW'(MAX_ROWS);
        end
        else
        begin
            nr = NRW'(rows_reg);
        end
        nc    = (cols_reg < 16'd3) ? 16'd3 : cols_reg;
        c_cur = (cpos_reg >= nc) ? 16'd0 : cpos_reg;
        r_cur = (NRW'(rpos_reg) >= nr) ? '0 : rpos_reg;
        r_ext = NRW'(r_cur);
        c_inc = {1'b0, c_cur} + 17'd1;
        if ((r_ext + NRW'(1)) >= nr)
        begin
            rpos_next = '0;
            cpos_next = (c_inc >= {1'b0, nc}) ? 16'd0 : c_inc[15:0];
        end
        else
        begin
            rpos_next = r_cur + 1'b1;
            cpos_next = c_cur;
        end
    end

    logic           interior_reg;
    logic           last_reg;
    logic [9:0]     crow_reg;
    logic [15:0]    ccol_reg;
    logic [16:0]    word_reg;
    logic [AW-1:0]  here_reg;
    logic [AW-1:0]  other_reg;
    logic [NRW-1:0] r_m1;
    logic [15:0]    c_m1;

    assign r_m1 = r_ext - NRW'(1);
    assign c_m1 = c_cur - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpos_reg     <= '0;
            cpos_reg     <= '0;
            interior_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            rpos_reg     <= rpos_next;
            cpos_reg     <= cpos_next;
            interior_reg <= (r_ext >= NRW'(2)) && (c_cur >= 16'd2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            last_reg  <= (r_ext == nr - NRW'(1)) && (c_cur == nc - 16'd1);
            crow_reg  <= r_m1[9:0];
            ccol_reg  <= c_m1;
            word_reg  <= {in_data.is_missing, in_data.sample};
            here_reg  <= {c_cur[0], r_cur};
            other_reg <= {~c_cur[0], r_cur};
        end
    end

    // column store
    logic [16:0]   store_mem [2**AW];
    logic [16:0]   rdata_reg;
    logic [16:0]   here_word_reg;
    logic [AW-1:0] rd_addr;

    assign rd_addr = cmd.rd_here ? here_reg : other_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.win_step)
        begin
            store_mem[here_reg] <= word_reg;
        end
        rdata_reg <= store_mem[rd_addr];
        if (cmd.rd_other)
        begin
            here_word_reg <= rdata_reg;
        end
    end

    // 3x3 window, win_reg[column][row]
    logic [16:0] win_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (cmd.win_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= here_word_reg;
            win_reg[1][2] <= rdata_reg;
            win_reg[2][2] <= word_reg;
        end
    end

    // weighted sum of present neighbours
    logic signed [20:0] e_sum, d_sum, tot;
    logic signed [4:0]  e_cnt, d_cnt, num;
    logic [16:0]        edges [4];
    logic [16:0]        diags [4];

    always_comb
    begin
        edges[0] = win_reg[1][0];
        edges[1] = win_reg[2][1];
        edges[2] = win_reg[1][2];
        edges[3] = win_reg[0][1];
        diags[0] = win_reg[0][0];
        diags[1] = win_reg[2][0];
        diags[2] = win_reg[0][2];
        diags[3] = win_reg[2][2];
        e_sum = '0;
        d_sum = '0;
        e_cnt = '0;
        d_cnt = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (!edges[i][16])
            begin
                e_sum = e_sum + 21'(signed'(edges[i][15:0]));
                e_cnt = e_cnt + 5'sd1;
            end
            if (!diags[i][16])
            begin
                d_sum = d_sum + 21'(signed'(diags[i][15:0]));
                d_cnt = d_cnt + 5'sd1;
            end
        end
        if (mode_reg)
        begin
            tot = (e_sum <<< 1) - d_sum;
            num = (e_cnt <<< 1) - d_cnt;
        end
        else
        begin
            tot = e_sum;
            num = e_cnt;
        end
    end

    // restoring divider on magnitudes, one quotient bit a cycle
    logic [DIV_BITS-1:0] quot_reg;
    logic [3:0]          rem_reg;
    logic [3:0]          den_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic [20:0]         tot_mag;
    logic [4:0]          num_mag;
    logic [4:0]          trial;

    assign tot_mag = tot[20] ? 21'(-tot) : 21'(tot);
    assign num_mag = num[4] ? 5'(-num) : 5'(num);
    assign trial   = {rem_reg, quot_reg[DIV_BITS-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quot_reg <= tot_mag[DIV_BITS-1:0];
            rem_reg  <= '0;
            den_reg  <= num_mag[3:0];
            neg_reg  <= tot[20] ^ num[4];
            zero_reg <= (num == 5'sd0);
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg  <= 4'(trial - {1'b0, den_reg});
                quot_reg <= {quot_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[3:0];
                quot_reg <= {quot_reg[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    // output register
    logic        out_valid_reg;
    out_beat_t   out_data_reg;
    logic [19:0] q_ext;

    assign q_ext = 20'(quot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.estimate      <= zero_reg ? 20'sd0 :
                                          (neg_reg ? signed'(-q_ext) : signed'(q_ext));
            out_data_reg.no_divisor    <= zero_reg;
            out_data_reg.centre_row    <= crow_reg;
            out_data_reg.centre_col    <= ccol_reg;
            out_data_reg.last_of_image <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.interior = interior_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

endmodule
